// ----- rtl/zotl_pkg.sv -----
// Shared types, widths and codes of the zone offset transition lookup block.
package zotl_pkg;

  // Table geometry
  localparam int MAX_TRANSITIONS = 64;
  localparam int ADDR_W          = $clog2(MAX_TRANSITIONS);
  localparam int SPAN_W          = ADDR_W + 1;

  // Field widths
  localparam int FUNC_W    = 2;
  localparam int INDEX_W   = 6;
  localparam int INST_W    = 41;
  localparam int OFF_W     = 17;
  localparam int SAV_W     = 18;
  localparam int COUNT_W   = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 17;
  localparam int ENTRY_W   = OFF_W + INST_W;

  // Stream word widths
  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 56;

  // Command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_QUERY   = 2'd0,
    FUNC_WR_STD  = 2'd1,
    FUNC_WR_WALL = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STD_COUNT  = 2'd0,
    CFG_WALL_COUNT = 2'd1,
    CFG_BASE_STD   = 2'd2,
    CFG_BASE_WALL  = 2'd3
  } cfg_index_e;

  typedef enum logic [1:0] {
    CMD_QUERY,
    CMD_WR_STD,
    CMD_WR_WALL
  } cmd_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    cmd_kind_e                 kind;
    logic [INDEX_W-1:0]        index;
    logic signed [INST_W-1:0]  instant;
    logic signed [OFF_W-1:0]   offset;
  } cmd_t;

  typedef struct packed {
    logic [COUNT_W-1:0]        std_count;
    logic [COUNT_W-1:0]        wall_count;
    logic signed [OFF_W-1:0]   base_std;
    logic signed [OFF_W-1:0]   base_wall;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic probe;
    logic compare;
  } tbl_ctl_t;

  typedef struct packed {
    logic                      is_daylight;
    logic signed [SAV_W-1:0]   savings;
    logic signed [OFF_W-1:0]   std_off;
    logic signed [OFF_W-1:0]   wall_off;
  } result_t;

endpackage

// ----- rtl/zotl_fifo.sv -----
// Short command queue between the front decoder and the back search engine.
module zotl_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  zotl_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output zotl_pkg::cmd_t head_o
);

  zotl_pkg::cmd_t                store_q [zotl_pkg::QDEPTH];
  logic [zotl_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [zotl_pkg::QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [zotl_pkg::QPTR_W:0]     fill_q, fill_d;
  logic                          do_push, do_pop;

  assign full_o  = (fill_q == (zotl_pkg::QPTR_W+1)'(zotl_pkg::QDEPTH));
  assign empty_o = (fill_q == '0);
  assign head_o  = store_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/zotl_front.sv -----
// Front end: take stream words, decode the function and queue commands.
module zotl_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: entry_index[5:0], epoch_second[46:6], offset_after[63:47]
  input  logic [zotl_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // tuser: func[1:0]
  input  logic [zotl_pkg::FUNC_W-1:0]     s_axis_tuser,
  input  logic                            pop_i,
  output logic                            empty_o,
  output zotl_pkg::cmd_t                  head_o
);

  zotl_pkg::cmd_t cmd;
  logic           known;
  logic           full;
  logic           push;

  // Decode the function code; drop unknown codes
  always_comb begin
    cmd.index   = s_axis_tdata[zotl_pkg::INDEX_W-1:0];
    cmd.instant = s_axis_tdata[zotl_pkg::INDEX_W +: zotl_pkg::INST_W];
    cmd.offset  = s_axis_tdata[zotl_pkg::INDEX_W+zotl_pkg::INST_W +: zotl_pkg::OFF_W];
    cmd.kind    = zotl_pkg::CMD_QUERY;
    known       = 1'b1;
    case (zotl_pkg::func_e'(s_axis_tuser))
      zotl_pkg::FUNC_QUERY:   cmd.kind = zotl_pkg::CMD_QUERY;
      zotl_pkg::FUNC_WR_STD:  cmd.kind = zotl_pkg::CMD_WR_STD;
      zotl_pkg::FUNC_WR_WALL: cmd.kind = zotl_pkg::CMD_WR_WALL;
      default:                known    = 1'b0;
    endcase
  end

  assign s_axis_tready = !full;
  assign push          = s_axis_tvalid && s_axis_tready && known;

  zotl_fifo u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (cmd),
    .full_o      (full),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .head_o      (head_o)
  );

endmodule

// ----- rtl/zotl_table.sv -----
// One transition table: entry memory plus its binary search registers.
module zotl_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  zotl_pkg::tbl_ctl_t                  ctl_i,
  input  logic                                wr_en_i,
  input  logic [zotl_pkg::ADDR_W-1:0]         wr_addr_i,
  input  logic signed [zotl_pkg::INST_W-1:0]  wr_inst_i,
  input  logic signed [zotl_pkg::OFF_W-1:0]   wr_off_i,
  input  logic signed [zotl_pkg::INST_W-1:0]  query_i,
  input  logic [zotl_pkg::COUNT_W-1:0]        count_i,
  input  logic signed [zotl_pkg::OFF_W-1:0]   base_i,
  output logic                                done_o,
  output logic signed [zotl_pkg::OFF_W-1:0]   offset_o
);

  logic [zotl_pkg::ENTRY_W-1:0]        mem_q [zotl_pkg::MAX_TRANSITIONS];
  logic [zotl_pkg::ENTRY_W-1:0]        rd_q;
  logic [zotl_pkg::SPAN_W-1:0]         lo_q, lo_d, hi_q, hi_d;
  logic [zotl_pkg::ADDR_W-1:0]         mid_q;
  logic signed [zotl_pkg::OFF_W-1:0]   best_q, best_d;
  logic [zotl_pkg::SPAN_W:0]           span_sum;
  logic [zotl_pkg::ADDR_W-1:0]         mid;
  logic [zotl_pkg::SPAN_W-1:0]         limit;
  logic signed [zotl_pkg::INST_W-1:0]  rd_inst;
  logic signed [zotl_pkg::OFF_W-1:0]   rd_off;

  // Midpoint of the half-open interval; lo < hi keeps it below the depth
  assign span_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = span_sum[zotl_pkg::SPAN_W-1:1];
  assign done_o   = (lo_q >= hi_q);
  assign offset_o = best_q;
  assign rd_inst  = rd_q[zotl_pkg::INST_W-1:0];
  assign rd_off   = rd_q[zotl_pkg::INST_W +: zotl_pkg::OFF_W];

  // Clamp the entry count to the table depth
  always_comb begin
    if (count_i > zotl_pkg::COUNT_W'(zotl_pkg::MAX_TRANSITIONS)) begin
      limit = zotl_pkg::SPAN_W'(zotl_pkg::MAX_TRANSITIONS);
    end else begin
      limit = zotl_pkg::SPAN_W'(count_i);
    end
  end

  // Load the search interval, then narrow it on each compare
  always_comb begin
    lo_d   = lo_q;
    hi_d   = hi_q;
    best_d = best_q;
    if (ctl_i.load) begin
      lo_d   = '0;
      hi_d   = limit;
      best_d = base_i;
    end else if (ctl_i.compare && !done_o) begin
      if (rd_inst <= query_i) begin
        lo_d   = {1'b0, mid_q} + 1'b1;
        best_d = rd_off;
      end else begin
        hi_d = {1'b0, mid_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= '0;
      hi_q <= '0;
    end else begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
  end

  // Write entries and read the probed entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= {wr_off_i, wr_inst_i};
    end
    if (ctl_i.probe) begin
      rd_q  <= mem_q[mid];
      mid_q <= mid;
    end
  end

endmodule

// ----- rtl/zotl_back.sv -----
// Back end: execute queued writes and queries, hold the result word.
module zotl_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  zotl_pkg::cfg_t                  cfg_i,
  input  logic                            empty_i,
  input  zotl_pkg::cmd_t                  head_i,
  output logic                            pop_o,
  output logic                            m_valid_o,
  input  logic                            m_ready_i,
  output zotl_pkg::result_t               result_o
);

  zotl_pkg::state_e                    state_q, state_d;
  logic                                out_valid_q, out_valid_d;
  zotl_pkg::result_t                   res_q, res_d;
  logic signed [zotl_pkg::INST_W-1:0]  query_q;
  zotl_pkg::tbl_ctl_t                  ctl;
  logic                                wr_std, wr_wall, load_out;
  logic                                std_done, wall_done;
  logic signed [zotl_pkg::OFF_W-1:0]   std_off, wall_off;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      zotl_pkg::ST_IDLE: begin
        if (!empty_i && head_i.kind == zotl_pkg::CMD_QUERY) begin
          state_d = zotl_pkg::ST_PROBE;
        end
      end
      zotl_pkg::ST_PROBE: begin
        state_d = (std_done && wall_done) ? zotl_pkg::ST_EMIT : zotl_pkg::ST_COMPARE;
      end
      zotl_pkg::ST_COMPARE: state_d = zotl_pkg::ST_PROBE;
      zotl_pkg::ST_EMIT: begin
        if (!out_valid_q || m_ready_i) begin
          state_d = zotl_pkg::ST_IDLE;
        end
      end
      default: state_d = zotl_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    pop_o       = 1'b0;
    wr_std      = 1'b0;
    wr_wall     = 1'b0;
    load_out    = 1'b0;
    ctl.load    = 1'b0;
    ctl.probe   = 1'b0;
    ctl.compare = 1'b0;
    case (state_q)
      zotl_pkg::ST_IDLE: begin
        pop_o    = !empty_i;
        wr_std   = !empty_i && head_i.kind == zotl_pkg::CMD_WR_STD;
        wr_wall  = !empty_i && head_i.kind == zotl_pkg::CMD_WR_WALL;
        ctl.load = !empty_i && head_i.kind == zotl_pkg::CMD_QUERY;
      end
      zotl_pkg::ST_PROBE:   ctl.probe   = !(std_done && wall_done);
      zotl_pkg::ST_COMPARE: ctl.compare = 1'b1;
      zotl_pkg::ST_EMIT:    load_out    = !out_valid_q || m_ready_i;
      default: ;
    endcase
  end

  // Form the result word
  always_comb begin
    res_d             = res_q;
    out_valid_d       = out_valid_q;
    if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      res_d.wall_off    = wall_off;
      res_d.std_off     = std_off;
      res_d.savings     = zotl_pkg::SAV_W'(wall_off) - zotl_pkg::SAV_W'(std_off);
      res_d.is_daylight = (wall_off != std_off);
      out_valid_d       = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= zotl_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload: query instant and result
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (ctl.load) begin
      query_q <= head_i.instant;
    end
  end

  assign m_valid_o = out_valid_q;
  assign result_o  = res_q;

  zotl_table u_std (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .wr_en_i   (wr_std),
    .wr_addr_i (head_i.index[zotl_pkg::ADDR_W-1:0]),
    .wr_inst_i (head_i.instant),
    .wr_off_i  (head_i.offset),
    .query_i   (query_q),
    .count_i   (cfg_i.std_count),
    .base_i    (cfg_i.base_std),
    .done_o    (std_done),
    .offset_o  (std_off)
  );

  zotl_table u_wall (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .wr_en_i   (wr_wall),
    .wr_addr_i (head_i.index[zotl_pkg::ADDR_W-1:0]),
    .wr_inst_i (head_i.instant),
    .wr_off_i  (head_i.offset),
    .query_i   (query_q),
    .count_i   (cfg_i.wall_count),
    .base_i    (cfg_i.base_wall),
    .done_o    (wall_done),
    .offset_o  (wall_off)
  );

`ifndef SYNTH
  // Commands leave the queue only between items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == zotl_pkg::ST_IDLE && !empty_i))
    else $error("command popped outside idle");

  // A new result only comes from the emit state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == zotl_pkg::ST_EMIT))
    else $error("result raised outside emit");

  // Emit never overwrites a result still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && out_valid_q) |-> m_ready_i)
    else $error("pending result overwritten");

  // A compare always follows a probe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == zotl_pkg::ST_COMPARE) |-> $past(state_q == zotl_pkg::ST_PROBE))
    else $error("compare without probe");
`endif

endmodule

// ----- rtl/zone_offset_transition_lookup_core.sv -----
// Top level of the zone offset transition lookup: config registers, front and back.
//
// Input stream (s_axis): one word per command. tuser carries the function:
// query, write a standard-table entry or write a wall-table entry; the
// unused function code is dropped. Writes produce no output word.
// Output stream (m_axis): one word per query with the wall offset, the
// standard offset, their difference and the daylight flag.
// Configuration: cfg_we_i writes register cfg_index_i (0 standard count,
// 1 wall count, 2 base standard offset, 3 base wall offset);
// write only while no command is in flight.
// A four-word command queue decouples input from execution, so input is
// taken while the back end searches or while a result waits to be taken.
// In the back end a query alternates probe and compare states until both table searches
// are done, then emits. Each search step is one memory read and one 41-bit compare, both
// tables stepped together.
// A stalled m_axis_tready holds the result word; the back end finishes at most
// one more query, then waits in its emit state and the queue fills, after
// which s_axis_tready drops.
// Reset clears the queue, the control state and the config registers;
// table entries are undefined until written.
module zone_offset_transition_lookup_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [zotl_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [zotl_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: entry_index[5:0], epoch_second[46:6], offset_after[63:47]
  input  logic [zotl_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // tuser: func[1:0]
  input  logic [zotl_pkg::FUNC_W-1:0]       s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: wall_offset[16:0], standard_offset[33:17], savings_seconds[51:34],
  //        is_daylight[52], zero[55:53]
  output logic [zotl_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

  zotl_pkg::cfg_t     cfg_q, cfg_d;
  zotl_pkg::cmd_t     head;
  zotl_pkg::result_t  result;
  logic               empty, pop;

  // Decode config writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (zotl_pkg::cfg_index_e'(cfg_index_i))
        zotl_pkg::CFG_STD_COUNT:  cfg_d.std_count  = cfg_data_i[zotl_pkg::COUNT_W-1:0];
        zotl_pkg::CFG_WALL_COUNT: cfg_d.wall_count = cfg_data_i[zotl_pkg::COUNT_W-1:0];
        zotl_pkg::CFG_BASE_STD:   cfg_d.base_std   = cfg_data_i[zotl_pkg::OFF_W-1:0];
        zotl_pkg::CFG_BASE_WALL:  cfg_d.base_wall  = cfg_data_i[zotl_pkg::OFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  zotl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .pop_i         (pop),
    .empty_o       (empty),
    .head_o        (head)
  );

  zotl_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .empty_i   (empty),
    .head_i    (head),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .result_o  (result)
  );

  // Pack the result word, lowest field first
  assign m_axis_tdata = zotl_pkg::M_TDATA_W'({result.is_daylight, result.savings,
                                              result.std_off, result.wall_off});

endmodule

// ----- bench/zone_offset_transition_lookup_core_tb.sv -----
// Self-checking testbench for the zone offset transition lookup core.
module zone_offset_transition_lookup_core_tb;
  import zotl_pkg::*;

  localparam logic [FUNC_W-1:0]        FUNC_UNUSED    = 2'd3;
  localparam logic signed [INST_W-1:0] EPOCH_MIN      = {1'b1, {(INST_W-1){1'b0}}};
  localparam logic signed [INST_W-1:0] EPOCH_MAX      = {1'b0, {(INST_W-1){1'b1}}};
  localparam int                       OFFSET_LIMIT   = 64800;
  localparam int                       SETTLE_CYCLES  = 64;
  localparam int                       WATCHDOG_LIMIT = 2000;
  localparam int                       RANDOM_ITEMS   = 1600;

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_W-1:0]       cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // tdata: entry_index[5:0], epoch_second[46:6], offset_after[63:47]
  logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
  // tuser: func[1:0]
  logic [FUNC_W-1:0]      s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // tdata: wall_offset[16:0], standard_offset[33:17], savings_seconds[51:34],
  //        is_daylight[52], zero[55:53]
  logic [M_TDATA_W-1:0]   m_axis_tdata;

  zone_offset_transition_lookup_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Shadow copy of the tables and registers
  logic signed [INST_W-1:0] std_instant  [MAX_TRANSITIONS];
  logic signed [OFF_W-1:0]  std_offset   [MAX_TRANSITIONS];
  logic signed [INST_W-1:0] wall_instant [MAX_TRANSITIONS];
  logic signed [OFF_W-1:0]  wall_offset  [MAX_TRANSITIONS];
  logic [COUNT_W-1:0]       std_count  = '0;
  logic [COUNT_W-1:0]       wall_count = '0;
  logic signed [OFF_W-1:0]  base_std   = '0;
  logic signed [OFF_W-1:0]  base_wall  = '0;

  result_t pending_offsets[$];

  int errors     = 0;
  int n_sent     = 0;
  int n_queries  = 0;
  int n_writes   = 0;
  int n_dropped  = 0;
  int n_settings = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Number of entries a search covers: counts above the table size clamp
  function automatic int live_entries(bit wall_side);
    int n;
    n = wall_side ? int'(wall_count) : int'(std_count);
    return (n > MAX_TRANSITIONS) ? MAX_TRANSITIONS : n;
  endfunction

  // Insertion-point search: offset after the last instant at or before t
  function automatic logic signed [OFF_W-1:0] search_offset(bit wall_side,
                                                            logic signed [INST_W-1:0] t);
    int lo;
    int hi;
    int mid;
    logic signed [INST_W-1:0] probe;
    lo = 0;
    hi = live_entries(wall_side);
    while (lo < hi) begin
      mid   = (lo + hi) / 2;
      probe = wall_side ? wall_instant[mid] : std_instant[mid];
      if (probe <= t) lo = mid + 1;
      else hi = mid;
    end
    if (lo == 0) return wall_side ? base_wall : base_std;
    return wall_side ? wall_offset[lo-1] : std_offset[lo-1];
  endfunction

  function automatic result_t predict_offsets(logic signed [INST_W-1:0] t);
    result_t r;
    r.wall_off    = search_offset(1'b1, t);
    r.std_off     = search_offset(1'b0, t);
    r.savings     = {r.wall_off[OFF_W-1], r.wall_off} - {r.std_off[OFF_W-1], r.std_off};
    r.is_daylight = (r.wall_off != r.std_off);
    return r;
  endfunction

  function automatic logic signed [INST_W-1:0] rand_epoch();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[INST_W-1:0];
  endfunction

  function automatic longint unsigned rand_below(longint unsigned bound);
    longint unsigned r;
    r = {$urandom, $urandom};
    return r % bound;
  endfunction

  // Favor a few common offsets so equal wall and standard offsets show up
  function automatic logic signed [OFF_W-1:0] rand_offset();
    int v;
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 5))
        0: v = -OFFSET_LIMIT;
        1: v = OFFSET_LIMIT;
        2: v = 0;
        3: v = 3600;
        4: v = 7200;
        default: v = -3600;
      endcase
    end else begin
      v = int'($urandom_range(0, 2 * OFFSET_LIMIT)) - OFFSET_LIMIT;
    end
    return OFF_W'(v);
  endfunction

  // Send one word in bursts with random gaps; update the shadow on acceptance
  task automatic send_word(logic [FUNC_W-1:0] func, logic [INDEX_W-1:0] idx,
                           logic signed [INST_W-1:0] t, logic signed [OFF_W-1:0] off);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 200)
                                               : $urandom_range(1, 24);
      gap = $urandom_range(0, 10);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {off, t, idx};
    s_axis_tuser  <= func;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
    case (func)
      FUNC_QUERY: begin
        pending_offsets.push_back(predict_offsets(t));
        n_queries++;
      end
      FUNC_WR_STD: begin
        std_instant[idx] = t;
        std_offset[idx]  = off;
        n_writes++;
      end
      FUNC_WR_WALL: begin
        wall_instant[idx] = t;
        wall_offset[idx]  = off;
        n_writes++;
      end
      default: n_dropped++;
    endcase
  endtask

  // Hold input, wait for every lookup, then let trailing writes drain
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (pending_offsets.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_index_e idx, logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_STD_COUNT:  std_count  = value[COUNT_W-1:0];
      CFG_WALL_COUNT: wall_count = value[COUNT_W-1:0];
      CFG_BASE_STD:   base_std   = value;
      CFG_BASE_WALL:  base_wall  = value;
      default: ;
    endcase
    n_settings++;
  endtask

  // Fill the entries a count will cover, mostly sorted with random spacing
  task automatic load_table(bit wall_side, int count);
    int n;
    int mode;
    longint unsigned span;
    longint unsigned step_max;
    longint unsigned at;
    logic signed [INST_W-1:0] t;
    n    = (count > MAX_TRANSITIONS) ? MAX_TRANSITIONS : count;
    mode = $urandom_range(0, 9);
    span = 64'd1 << INST_W;
    if (mode <= 3) step_max = 2;
    else if (mode <= 6) step_max = 64'd1 << 20;
    else step_max = (span - 1) / ((n == 0) ? 1 : n);
    at = rand_below(span - n * step_max);
    for (int i = 0; i < n; i++) begin
      if (mode == 0) begin
        t = rand_epoch();
      end else begin
        at += rand_below(step_max + 1);
        t = EPOCH_MIN + INST_W'(at);
      end
      send_word(wall_side ? FUNC_WR_WALL : FUNC_WR_STD, INDEX_W'(i), t, rand_offset());
    end
  endtask

  // Mostly lookups, about half of them around stored instants, with some writes and dropped codes
  task automatic run_traffic(int items);
    int pick;
    int live;
    bit side;
    logic [INDEX_W-1:0] idx;
    logic signed [INST_W-1:0] t;
    repeat (items) begin
      pick = $urandom_range(0, 99);
      side = 1'($urandom_range(0, 1));
      live = live_entries(side);
      if (pick < 70) begin
        if (pick < 35 && live != 0) begin
          idx = INDEX_W'($urandom_range(0, live - 1));
          t   = (side ? wall_instant[idx] : std_instant[idx]) + INST_W'($urandom_range(0, 2))
                - 1;
        end else if (pick < 42) begin
          t = $urandom_range(0, 1) ? EPOCH_MIN : EPOCH_MAX;
        end else begin
          t = rand_epoch();
        end
        send_word(FUNC_QUERY, INDEX_W'($urandom), t, rand_offset());
      end else if (pick < 94) begin
        // keep most writes past the live entries so tables stay mostly sorted
        if (live < MAX_TRANSITIONS && $urandom_range(0, 3) != 0)
          idx = INDEX_W'($urandom_range(live, MAX_TRANSITIONS - 1));
        else
          idx = INDEX_W'($urandom_range(0, MAX_TRANSITIONS - 1));
        send_word(side ? FUNC_WR_WALL : FUNC_WR_STD, idx, rand_epoch(), rand_offset());
      end else begin
        send_word(FUNC_UNUSED, INDEX_W'($urandom), rand_epoch(), rand_offset());
      end
    end
  endtask

  // Empty tables: base offsets only, at zero, at their extremes and equal
  task automatic test_empty_tables();
    send_word(FUNC_QUERY, '1, EPOCH_MIN, -OFFSET_LIMIT);
    send_word(FUNC_QUERY, '0, EPOCH_MAX, OFFSET_LIMIT);
    send_word(FUNC_QUERY, '1, '0, '0);
    settle_block();
    write_register(CFG_BASE_STD, CFG_W'(-OFFSET_LIMIT));
    write_register(CFG_BASE_WALL, CFG_W'(OFFSET_LIMIT));
    send_word(FUNC_QUERY, '0, rand_epoch(), '0);
    settle_block();
    write_register(CFG_BASE_STD, CFG_W'(OFFSET_LIMIT));
    write_register(CFG_BASE_WALL, CFG_W'(-OFFSET_LIMIT));
    send_word(FUNC_QUERY, '0, rand_epoch(), '0);
    settle_block();
    write_register(CFG_BASE_STD, CFG_W'(3600));
    write_register(CFG_BASE_WALL, CFG_W'(3600));
    send_word(FUNC_QUERY, '0, rand_epoch(), '0);
    settle_block();
  endtask

  // Queries just before, on and after instants, equal instants, past the end
  task automatic test_boundary_instants();
    send_word(FUNC_WR_STD, 6'd0, 41'sd100, 17'sd3600);
    send_word(FUNC_WR_STD, 6'd1, 41'sd200, -17'sd64800);
    send_word(FUNC_WR_WALL, 6'd0, 41'sd100, 17'sd7200);
    send_word(FUNC_WR_WALL, 6'd1, 41'sd100, 17'sd64800);
    send_word(FUNC_WR_WALL, 6'd2, EPOCH_MAX, -17'sd3600);
    settle_block();
    write_register(CFG_STD_COUNT, CFG_W'(2));
    write_register(CFG_WALL_COUNT, CFG_W'(3));
    send_word(FUNC_QUERY, '0, 41'sd99, '0);
    send_word(FUNC_QUERY, '0, 41'sd100, '0);
    send_word(FUNC_QUERY, '0, 41'sd101, '0);
    send_word(FUNC_QUERY, '0, 41'sd200, '0);
    send_word(FUNC_QUERY, '0, EPOCH_MAX, '0);
    send_word(FUNC_QUERY, '0, EPOCH_MIN, '0);
    settle_block();
  endtask

  // Out-of-order instants: the search outcome is still fixed
  task automatic test_unsorted_table();
    send_word(FUNC_WR_STD, 6'd0, 41'sd300, 17'sd600);
    send_word(FUNC_WR_STD, 6'd1, 41'sd100, 17'sd1200);
    send_word(FUNC_WR_STD, 6'd2, 41'sd200, 17'sd1800);
    settle_block();
    write_register(CFG_STD_COUNT, CFG_W'(3));
    send_word(FUNC_QUERY, '0, 41'sd150, '0);
    send_word(FUNC_QUERY, '0, 41'sd250, '0);
    settle_block();
  endtask

  // Unused function code: no result word, no table change
  task automatic test_unknown_func();
    send_word(FUNC_UNUSED, '1, 41'sd150, 17'sd900);
    send_word(FUNC_UNUSED, '0, rand_epoch(), rand_offset());
    send_word(FUNC_QUERY, '0, 41'sd150, '0);
    settle_block();
  endtask

  // Random phases: new sizes, sometimes new bases, fresh tables, then mixed traffic
  task automatic test_random_phases();
    int start;
    int n_std;
    int n_wall;
    start = n_sent;
    while (n_sent - start < RANDOM_ITEMS) begin
      for (int k = 0; k < 2; k++) begin
        case ($urandom_range(0, 19))
          0, 1, 2:  n_wall = MAX_TRANSITIONS;
          3:        n_wall = $urandom_range(MAX_TRANSITIONS + 1, (1 << COUNT_W) - 1);
          4, 5, 6:  n_wall = $urandom_range(9, MAX_TRANSITIONS - 1);
          default:  n_wall = $urandom_range(0, 8);
        endcase
        if (k == 0) n_std = n_wall;
      end
      load_table(1'b0, n_std);
      load_table(1'b1, n_wall);
      settle_block();
      write_register(CFG_STD_COUNT, CFG_W'(n_std));
      write_register(CFG_WALL_COUNT, CFG_W'(n_wall));
      if ($urandom_range(0, 1) == 0) begin
        write_register(CFG_BASE_STD, rand_offset());
        write_register(CFG_BASE_WALL, rand_offset());
      end
      run_traffic($urandom_range(30, 120));
      settle_block();
    end
  endtask

  // Receiver: switch among always ready, random ready and long stalls
  int stall_left = 0;
  int rx_mode    = 0;
  int rx_cycle   = 0;
  always @(posedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 257 == 0) rx_mode = $urandom_range(0, 2);
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_mode == 1) begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end else if (rx_mode == 2 && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(1, 40);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each result word with the oldest predicted lookup
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
      if (pending_offsets.size() == 0) begin
        $error("result word 0x%h with no lookup waiting", m_axis_tdata);
        errors++;
      end else begin
        want = pending_offsets.pop_front();
        if (got.wall_off != want.wall_off) begin
          $error("wall_offset: expected %0d, got %0d", want.wall_off, got.wall_off);
          errors++;
        end
        if (got.std_off != want.std_off) begin
          $error("standard_offset: expected %0d, got %0d", want.std_off, got.std_off);
          errors++;
        end
        if (got.savings != want.savings) begin
          $error("savings_seconds: expected %0d, got %0d", want.savings, got.savings);
          errors++;
        end
        if (got.is_daylight != want.is_daylight) begin
          $error("is_daylight: expected %0d, got %0d", want.is_daylight, got.is_daylight);
          errors++;
        end
      end
    end
  end

  // Watchdog: stop when no word moves on either side for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_tables();
    test_boundary_instants();
    test_unsorted_table();
    test_unknown_func();
    test_random_phases();
    settle_block();
    $display("checked %0d lookups over %0d table writes and %0d register writes,",
             n_queries, n_writes, n_settings);
    $display("with %0d unused-code words dropped, under random input gaps and output stalls",
             n_dropped);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/zotl_pkg.sv
rtl/zotl_fifo.sv
rtl/zotl_front.sv
rtl/zotl_table.sv
rtl/zotl_back.sv
rtl/zone_offset_transition_lookup_core.sv
bench/zone_offset_transition_lookup_core_tb.sv
